>>> hw/rtl/jsu_pkg.sv
// Shared types, codes and helpers for the JSON string unescaper.
`default_nettype none
package jsu_pkg;

   localparam int unsigned JOB_BYTES   = 4;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] CAP_RESET = 16'hffff;

   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6e;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;

   typedef enum logic [1:0] {
      ST_DATA = 2'd0,
      ST_DONE = 2'd1,
      ST_FAIL = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      PH_PLAIN   = 4'd0,
      PH_ESC     = 4'd1,
      PH_HEX0    = 4'd2,
      PH_HEX1    = 4'd3,
      PH_HEX2    = 4'd4,
      PH_HEX3    = 4'd5,
      PH_WANT_BS = 4'd6,
      PH_WANT_U  = 4'd7,
      PH_LOW0    = 4'd8,
      PH_LOW1    = 4'd9,
      PH_LOW2    = 4'd10,
      PH_LOW3    = 4'd11
   } phase_type;

   // Results caused by one input beat: data bytes, then an optional status beat.
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] data;
      logic [2:0]                count;
      logic                      tail;
      status_type                tail_status;
   } job_type;

   // {valid, value} of an ASCII hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/jsu_front.sv
// Front end: escape decoding, UTF-8 encoding and capacity checks, one beat per cycle when accepted.
`default_nettype none
module jsu_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_accept,
   input  wire logic [7:0]        in_byte,
   input  wire logic              in_eos,
   input  wire logic              cap_we,
   input  wire logic [15:0]       cap_wdata,
   output jsu_pkg::job_type       job,
   output logic                   job_valid
);

   jsu_pkg::phase_type phase_ff, phase_in;
   logic [15:0]        acc_ff, acc_in;
   logic [9:0]         hs_ff, hs_in;
   logic [15:0]        bw_ff, bw_in;
   logic               failed_ff, failed_in;
   logic [15:0]        cap_ff;

   logic [4:0]         hex;
   logic [15:0]        acc_shift;
   logic               is_high, is_low, cap_zero, fail_now;

   logic               put_raw, put_cp;
   logic [7:0]         raw_byte;
   logic [20:0]        cp;

   logic [2:0]         seq_n, emitted;
   logic [3:0][7:0]    seq;
   logic signed [17:0] room;
   logic               fail_put, new_fail, failed_after;

   assign hex       = jsu_pkg::hex_digit(in_byte);
   assign acc_shift = {acc_ff[11:0], hex[3:0]};
   assign is_high   = acc_shift >= 16'hd800 && acc_shift <= 16'hdbff;
   assign is_low    = acc_shift >= 16'hdc00 && acc_shift <= 16'hdfff;
   assign cap_zero  = phase_ff == jsu_pkg::PH_PLAIN && bw_ff == 16'd0 && cap_ff == 16'd0;

   // Next state of the escape sequencer
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      hs_in    = hs_ff;
      fail_now = 1'b0;
      if (!failed_ff) begin
         if (cap_zero) begin
            fail_now = 1'b1;
         end else begin
            case (phase_ff)
               jsu_pkg::PH_ESC: begin
                  phase_in = jsu_pkg::PH_PLAIN;
                  if (in_byte == jsu_pkg::CH_U) begin
                     acc_in   = 16'd0;
                     phase_in = jsu_pkg::PH_HEX0;
                  end
               end
               jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3,
               jsu_pkg::PH_LOW0, jsu_pkg::PH_LOW1, jsu_pkg::PH_LOW2,
               jsu_pkg::PH_LOW3: begin
                  if (!hex[4]) begin
                     fail_now = 1'b1;
                  end else begin
                     acc_in = acc_shift;
                     if (phase_ff == jsu_pkg::PH_HEX3) begin
                        if (is_high) begin
                           hs_in    = acc_shift[9:0];
                           phase_in = jsu_pkg::PH_WANT_BS;
                        end else if (is_low) begin
                           fail_now = 1'b1;
                        end else begin
                           phase_in = jsu_pkg::PH_PLAIN;
                        end
                     end else if (phase_ff == jsu_pkg::PH_LOW3) begin
                        if (!is_low) begin
                           fail_now = 1'b1;
                        end else begin
                           phase_in = jsu_pkg::PH_PLAIN;
                        end
                     end else begin
                        phase_in = jsu_pkg::phase_type'(phase_ff + 4'd1);
                     end
                  end
               end
               jsu_pkg::PH_WANT_BS: begin
                  if (in_byte == jsu_pkg::CH_BSLASH) begin
                     phase_in = jsu_pkg::PH_WANT_U;
                  end else begin
                     fail_now = 1'b1;
                  end
               end
               jsu_pkg::PH_WANT_U: begin
                  if (in_byte == jsu_pkg::CH_U) begin
                     acc_in   = 16'd0;
                     phase_in = jsu_pkg::PH_LOW0;
                  end else begin
                     fail_now = 1'b1;
                  end
               end
               default: begin
                  phase_in = jsu_pkg::PH_PLAIN;
                  if (in_byte == jsu_pkg::CH_BSLASH) begin
                     phase_in = jsu_pkg::PH_ESC;
                  end
               end
            endcase
         end
      end
   end

   // What the beat writes: a raw byte or a code point
   always_comb begin
      put_raw  = 1'b0;
      put_cp   = 1'b0;
      raw_byte = in_byte;
      cp       = {5'd0, acc_shift};
      if (!failed_ff && !cap_zero) begin
         case (phase_ff)
            jsu_pkg::PH_ESC: begin
               put_raw = in_byte != jsu_pkg::CH_U;
               case (in_byte)
                  jsu_pkg::CH_B: raw_byte = 8'h08;
                  jsu_pkg::CH_F: raw_byte = 8'h0c;
                  jsu_pkg::CH_N: raw_byte = 8'h0a;
                  jsu_pkg::CH_R: raw_byte = 8'h0d;
                  jsu_pkg::CH_T: raw_byte = 8'h09;
                  default:       raw_byte = in_byte;
               endcase
            end
            jsu_pkg::PH_HEX3: begin
               put_cp = hex[4] && !is_high && !is_low;
            end
            jsu_pkg::PH_LOW3: begin
               put_cp = hex[4] && is_low;
               cp     = 21'h010000 + {1'b0, hs_ff, acc_shift[9:0]};
            end
            jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2,
            jsu_pkg::PH_LOW0, jsu_pkg::PH_LOW1, jsu_pkg::PH_LOW2,
            jsu_pkg::PH_WANT_BS, jsu_pkg::PH_WANT_U: begin
               put_raw = 1'b0;
            end
            default: begin
               put_raw = in_byte != jsu_pkg::CH_BSLASH;
            end
         endcase
      end
   end

   // UTF-8 byte sequence
   always_comb begin
      seq   = '0;
      seq_n = 3'd0;
      if (put_raw) begin
         seq[0] = raw_byte;
         seq_n  = 3'd1;
      end else if (put_cp) begin
         if (cp < 21'h80) begin
            seq[0] = cp[7:0];
            seq_n  = 3'd1;
         end else if (cp < 21'h800) begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
            seq_n  = 3'd2;
         end else if (cp < 21'h10000) begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
            seq_n  = 3'd3;
         end else begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
            seq_n  = 3'd4;
         end
      end
   end

   // Bytes that still fit: byte k goes out while k < cap - written - 1
   assign room = $signed({2'b00, cap_ff}) - $signed({2'b00, bw_ff}) - 18'sd1;

   always_comb begin
      fail_put = 1'b0;
      emitted  = seq_n;
      if (seq_n != 3'd0) begin
         if (seq[0] == 8'h00) begin
            fail_put = 1'b1;
            emitted  = 3'd0;
         end else if (room < $signed({15'd0, seq_n})) begin
            fail_put = 1'b1;
            emitted  = (room <= 18'sd0) ? 3'd0 : room[2:0];
         end
      end
   end

   assign new_fail     = fail_now || fail_put;
   assign failed_after = failed_ff || new_fail;

   always_comb begin
      job.data        = seq;
      job.count       = emitted;
      job.tail        = new_fail || (in_eos && !failed_after);
      job.tail_status = (new_fail || phase_in != jsu_pkg::PH_PLAIN) ?
                        jsu_pkg::ST_FAIL : jsu_pkg::ST_DONE;
      job_valid       = in_accept && (emitted != 3'd0 || job.tail);
   end

   assign bw_in     = bw_ff + {13'd0, emitted};
   assign failed_in = failed_after;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= jsu_pkg::PH_PLAIN;
         acc_ff    <= 16'd0;
         hs_ff     <= 10'd0;
         bw_ff     <= 16'd0;
         failed_ff <= 1'b0;
         cap_ff    <= jsu_pkg::CAP_RESET;
      end else begin
         if (cap_we) begin
            cap_ff <= cap_wdata;
         end
         if (in_accept) begin
            if (in_eos) begin
               phase_ff  <= jsu_pkg::PH_PLAIN;
               acc_ff    <= 16'd0;
               hs_ff     <= 10'd0;
               bw_ff     <= 16'd0;
               failed_ff <= 1'b0;
            end else begin
               phase_ff  <= phase_in;
               acc_ff    <= acc_in;
               hs_ff     <= hs_in;
               bw_ff     <= bw_in;
               failed_ff <= failed_in;
            end
         end
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/jsu_job_fifo.sv
// Short queue of decoded jobs between front and back end.
`default_nettype none
module jsu_job_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire jsu_pkg::job_type wr_job,
   input  wire logic             rd_en,
   output jsu_pkg::job_type      rd_job,
   output logic                  empty,
   output logic                  full
);

   jsu_pkg::job_type                  mem [jsu_pkg::QUEUE_DEPTH];
   logic [jsu_pkg::QUEUE_AW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [jsu_pkg::QUEUE_AW:0]        count_ff;

   assign empty  = count_ff == '0;
   assign full   = count_ff == (jsu_pkg::QUEUE_AW+1)'(jsu_pkg::QUEUE_DEPTH);
   assign rd_job = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (wr_en && !rd_en) begin
            count_ff <= count_ff + 1'b1;
         end else if (rd_en && !wr_en) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/jsu_back.sv
// Back end: walks the head job and presents one result beat per cycle while rsp_pop is high.
`default_nettype none
module jsu_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire jsu_pkg::job_type head,
   input  wire logic             head_empty,
   output logic                  head_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [7:0]            rsp_out_byte,
   output logic [1:0]            rsp_status,
   output logic                  rsp_run_last
);

   logic [2:0] idx_ff, idx_in;
   logic [2:0] total;
   logic       taken;

   assign total     = head.count + {2'b00, head.tail};
   assign rsp_empty = head_empty;
   assign taken     = rsp_pop && !head_empty;

   always_comb begin
      if (idx_ff < head.count) begin
         rsp_out_byte = head.data[idx_ff[1:0]];
         rsp_status   = jsu_pkg::ST_DATA;
      end else begin
         rsp_out_byte = 8'h00;
         rsp_status   = head.tail_status;
      end
      rsp_run_last = idx_ff == total - 3'd1;
   end

   assign head_pop = taken && rsp_run_last;
   assign idx_in   = head_pop ? 3'd0 : idx_ff + 3'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
      end else if (taken) begin
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/json_string_unescape_utf8_core.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
// Input channel (req_): one body byte of a JSON string per beat, taken when
// req_push is high and req_full is low; req_end_of_string marks the last one.
// Result channel (rsp_): queue-like; the oldest result sits on the rsp_ ports
// while rsp_empty is low and is taken when rsp_pop is high. Each input beat
// yields 0 to 5 results; rsp_run_last flags the last of them.
// Config channel (csr_): csr_wdata sets the output capacity; always ready.
// Results of a beat are written to the job queue and reach the rsp_ ports once older ones are taken.
// Throughput: one input beat per cycle while each yields at most one result and
// the receiver pops; the result port moves one result per cycle, so the bytes of a
// 4-byte UTF-8 sequence leave one by one. A 4-entry job queue decouples the two sides.
// When the receiver stalls, the queue fills and req_full rises.
// Reset clears decoder state and the queue and sets the capacity to 65535.
`default_nettype none
module json_string_unescape_utf8_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_body_byte,
   input  wire logic        req_end_of_string,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic [1:0]       rsp_status,
   output logic             rsp_run_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_wdata
);

   jsu_pkg::job_type front_job, head_job;
   logic             front_valid, q_empty, q_full, q_pop, accept;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_byte   (req_body_byte),
      .in_eos    (req_end_of_string),
      .cap_we    (csr_valid && csr_ready),
      .cap_wdata (csr_wdata),
      .job       (front_job),
      .job_valid (front_valid)
   );

   jsu_job_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (front_valid),
      .wr_job (front_job),
      .rd_en  (q_pop),
      .rd_job (head_job),
      .empty  (q_empty),
      .full   (q_full)
   );

   jsu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head_job),
      .head_empty   (q_empty),
      .head_pop     (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_run_last (rsp_run_last)
   );

endmodule
`default_nettype wire

>>> dv/json_string_unescape_utf8_core_tb.sv
// Self-checking testbench for the JSON string unescaper: table-driven and random strings.
`default_nettype none
module json_string_unescape_utf8_core_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 40;
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASE_BEATS = 20;

   typedef struct packed {
      logic [7:0]          out_byte;
      jsu_pkg::status_type status;
      logic                run_last;
   } unesc_result_type;

   typedef struct packed {
      logic [7:0]          b;
      logic                eos;
      logic                typed;
      logic [7:0]          want_byte;
      jsu_pkg::status_type want_st;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_body_byte = 8'h00;
   logic        req_end_of_string = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_status;
   logic        rsp_run_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata = 16'h0000;

   json_string_unescape_utf8_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_body_byte     (req_body_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_status        (rsp_status),
      .rsp_run_last      (rsp_run_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Decoder state mirror
   logic [15:0]        capacity = jsu_pkg::CAP_RESET;
   jsu_pkg::phase_type esc_phase = jsu_pkg::PH_PLAIN;
   logic [15:0]        hex_acc = 16'h0000;
   logic [9:0]         high_bits = 10'h000;
   logic [15:0]        nwritten = 16'h0000;
   logic               failed = 1'b0;

   unesc_result_type decoded_q[$];
   unesc_result_type beat_out[$];
   logic [7:0]       str_q[$];

   int req_gap_pct = 12;
   int rsp_gap_pct = 68;
   int cycle_count = 0;
   int mismatch_count = 0;
   logic hold_req = 1'b0;
   logic hold_seen = 1'b0;
   int hold_left = 0;
   unesc_result_type got_res, want_res;

   logic [15:0] cp_edges [6] = '{16'h0001, 16'h007f, 16'h0080, 16'h07ff, 16'h0800, 16'hffff};

   stim_row_type dir_rows [28] = '{
      '{8'hff,              1'b0, 1'b1, 8'hff, jsu_pkg::ST_DATA},
      '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{jsu_pkg::CH_T,      1'b0, 1'b1, 8'h09, jsu_pkg::ST_DATA},
      // U+20AC, mixed-case hex
      '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{jsu_pkg::CH_U,      1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h32,              1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h30,              1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h41,              1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h63,              1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h41,              1'b1, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      // surrogate pair, last beat yields four bytes plus done
      '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{jsu_pkg::CH_U,      1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h64,              1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h38,              1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h33,              1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h44,              1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{jsu_pkg::CH_U,      1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h64,              1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h45,              1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h30,              1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h30,              1'b1, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      // string ends inside an escape
      '{jsu_pkg::CH_BSLASH, 1'b1, 1'b1, 8'h00, jsu_pkg::ST_FAIL},
      // non-hex digit
      '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{jsu_pkg::CH_U,      1'b0, 1'b0, 8'h00, jsu_pkg::ST_DATA},
      '{8'h67,              1'b1, 1'b1, 8'h00, jsu_pkg::ST_FAIL},
      // raw zero, then a swallowed end byte
      '{8'h00,              1'b0, 1'b1, 8'h00, jsu_pkg::ST_FAIL},
      '{8'h80,              1'b1, 1'b0, 8'h00, jsu_pkg::ST_DATA}
   };

   function automatic int hex_val(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      return -1;
   endfunction

   function void queue_result(logic [7:0] v, jsu_pkg::status_type st);
      beat_out.push_back(unesc_result_type'{v, st, 1'b0});
   endfunction

   function void flag_failure();
      if (!failed) begin
         failed = 1'b1;
         queue_result(8'h00, jsu_pkg::ST_FAIL);
      end
   endfunction

   function void write_byte(logic [7:0] v);
      if (failed) return;
      if (v == 8'h00 || int'(nwritten) + 1 >= int'(capacity)) begin
         flag_failure();
         return;
      end
      queue_result(v, jsu_pkg::ST_DATA);
      nwritten = nwritten + 16'd1;
   endfunction

   function void encode_utf8(logic [20:0] cp);
      if (cp < 21'h80) begin
         write_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
         write_byte({3'b110, cp[10:6]});
         write_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         write_byte({4'b1110, cp[15:12]});
         write_byte({2'b10, cp[11:6]});
         write_byte({2'b10, cp[5:0]});
      end else begin
         write_byte({5'b11110, cp[20:18]});
         write_byte({2'b10, cp[17:12]});
         write_byte({2'b10, cp[11:6]});
         write_byte({2'b10, cp[5:0]});
      end
   endfunction

   function void step_phase(logic [7:0] b);
      int v;
      logic [7:0] c;
      case (esc_phase)
         jsu_pkg::PH_ESC: begin
            esc_phase = jsu_pkg::PH_PLAIN;
            if (b == jsu_pkg::CH_U) begin
               hex_acc = 16'h0000;
               esc_phase = jsu_pkg::PH_HEX0;
            end else begin
               case (b)
                  jsu_pkg::CH_B: c = 8'h08;
                  jsu_pkg::CH_F: c = 8'h0c;
                  jsu_pkg::CH_N: c = 8'h0a;
                  jsu_pkg::CH_R: c = 8'h0d;
                  jsu_pkg::CH_T: c = 8'h09;
                  default: c = b;
               endcase
               write_byte(c);
            end
         end
         jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3,
         jsu_pkg::PH_LOW0, jsu_pkg::PH_LOW1, jsu_pkg::PH_LOW2, jsu_pkg::PH_LOW3: begin
            v = hex_val(b);
            if (v < 0) begin
               flag_failure();
            end else begin
               hex_acc = {hex_acc[11:0], v[3:0]};
               if (esc_phase == jsu_pkg::PH_HEX3) begin
                  if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff) begin
                     high_bits = hex_acc[9:0];
                     esc_phase = jsu_pkg::PH_WANT_BS;
                  end else if (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff) begin
                     flag_failure();
                  end else begin
                     esc_phase = jsu_pkg::PH_PLAIN;
                     encode_utf8({5'd0, hex_acc});
                  end
               end else if (esc_phase == jsu_pkg::PH_LOW3) begin
                  if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff) begin
                     flag_failure();
                  end else begin
                     esc_phase = jsu_pkg::PH_PLAIN;
                     encode_utf8(21'h10000 + {1'b0, high_bits, hex_acc[9:0]});
                  end
               end else begin
                  esc_phase = jsu_pkg::phase_type'(esc_phase + 4'd1);
               end
            end
         end
         jsu_pkg::PH_WANT_BS: begin
            if (b == jsu_pkg::CH_BSLASH) esc_phase = jsu_pkg::PH_WANT_U;
            else flag_failure();
         end
         jsu_pkg::PH_WANT_U: begin
            if (b == jsu_pkg::CH_U) begin
               hex_acc = 16'h0000;
               esc_phase = jsu_pkg::PH_LOW0;
            end else begin
               flag_failure();
            end
         end
         default: begin
            esc_phase = jsu_pkg::PH_PLAIN;
            if (b == jsu_pkg::CH_BSLASH) esc_phase = jsu_pkg::PH_ESC;
            else write_byte(b);
         end
      endcase
   endfunction

   // Results of one accepted beat land in beat_out.
   function void unescape_beat(logic [7:0] b, logic eos);
      beat_out.delete();
      if (!failed) begin
         if (esc_phase == jsu_pkg::PH_PLAIN && nwritten == 16'd0 && capacity == 16'd0)
            flag_failure();
         else step_phase(b);
      end
      if (eos) begin
         if (!failed) begin
            if (esc_phase != jsu_pkg::PH_PLAIN) flag_failure();
            else queue_result(8'h00, jsu_pkg::ST_DONE);
         end
         esc_phase = jsu_pkg::PH_PLAIN;
         hex_acc = 16'h0000;
         high_bits = 10'h000;
         nwritten = 16'h0000;
         failed = 1'b0;
      end
      if (beat_out.size() > 0) beat_out[beat_out.size() - 1].run_last = 1'b1;
   endfunction

   function logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + {4'd0, nib};
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, nib} - 8'd10;
   endfunction

   function void push_hex4(logic [15:0] v);
      str_q.push_back(jsu_pkg::CH_BSLASH);
      str_q.push_back(jsu_pkg::CH_U);
      str_q.push_back(hex_char(v[15:12]));
      str_q.push_back(hex_char(v[11:8]));
      str_q.push_back(hex_char(v[7:4]));
      str_q.push_back(hex_char(v[3:0]));
   endfunction

   function void add_token();
      logic [7:0] c;
      logic [15:0] cp;
      case ($urandom_range(0, 11))
         0, 1, 2, 3: begin
            c = 8'($urandom_range(8'h20, 8'h7e));
            if (c == jsu_pkg::CH_BSLASH) c = 8'h2f;
            str_q.push_back(c);
         end
         4, 11: str_q.push_back(8'($urandom_range(0, 255)));
         5: begin
            case ($urandom_range(0, 8))
               0: c = jsu_pkg::CH_B;
               1: c = jsu_pkg::CH_F;
               2: c = jsu_pkg::CH_N;
               3: c = jsu_pkg::CH_R;
               4: c = jsu_pkg::CH_T;
               5: c = 8'h22;
               6: c = 8'h2f;
               7: c = jsu_pkg::CH_BSLASH;
               default: c = 8'($urandom_range(0, 255));
            endcase
            str_q.push_back(jsu_pkg::CH_BSLASH);
            str_q.push_back(c);
         end
         6, 7: begin
            case ($urandom_range(0, 5))
               0: cp = 16'($urandom_range(16'h0000, 16'h007f));
               1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
               2: cp = 16'($urandom_range(16'h0800, 16'hd7ff));
               3: cp = 16'($urandom_range(16'he000, 16'hffff));
               4: cp = cp_edges[$urandom_range(0, 5)];
               default: cp = 16'h0000;
            endcase
            push_hex4(cp);
         end
         8: begin
            push_hex4(16'($urandom_range(16'hd800, 16'hdbff)));
            push_hex4(16'($urandom_range(16'hdc00, 16'hdfff)));
         end
         default: begin
            // broken escapes and pairs
            case ($urandom_range(0, 4))
               0: push_hex4(16'($urandom_range(16'hdc00, 16'hdfff)));
               1: begin
                  push_hex4(16'($urandom_range(16'hd800, 16'hdbff)));
                  c = 8'($urandom_range(0, 255));
                  if (c == jsu_pkg::CH_BSLASH) c = 8'h41;
                  str_q.push_back(c);
               end
               2: begin
                  push_hex4(16'($urandom_range(16'hd800, 16'hdbff)));
                  str_q.push_back(jsu_pkg::CH_BSLASH);
                  c = 8'($urandom_range(0, 255));
                  if (c == jsu_pkg::CH_U) c = jsu_pkg::CH_N;
                  str_q.push_back(c);
               end
               3: begin
                  push_hex4(16'($urandom_range(16'hd800, 16'hdbff)));
                  push_hex4($urandom_range(0, 1) ? 16'($urandom_range(16'hd800, 16'hdbff))
                                                 : 16'($urandom_range(16'h0000, 16'hd7ff)));
               end
               default: begin
                  str_q.push_back(jsu_pkg::CH_BSLASH);
                  str_q.push_back(jsu_pkg::CH_U);
                  repeat ($urandom_range(0, 3))
                     str_q.push_back(hex_char(4'($urandom_range(0, 15))));
                  do c = 8'($urandom_range(0, 255)); while (hex_val(c) >= 0);
                  str_q.push_back(c);
               end
            endcase
         end
      endcase
   endfunction

   function void build_string();
      str_q.delete();
      repeat ($urandom_range(1, 6)) add_token();
      // sometimes end the string inside an escape
      if ($urandom_range(0, 9) == 0) begin
         str_q.push_back(jsu_pkg::CH_BSLASH);
         if ($urandom_range(0, 1)) begin
            str_q.push_back(jsu_pkg::CH_U);
            repeat ($urandom_range(0, 3))
               str_q.push_back(hex_char(4'($urandom_range(0, 15))));
         end
      end
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic eos, input logic typed,
                            input unesc_result_type typed_res);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_body_byte <= b;
      req_end_of_string <= eos;
      do @(posedge clock); while (req_full);
      unescape_beat(b, eos);
      if (typed) decoded_q.push_back(typed_res);
      else foreach (beat_out[j]) decoded_q.push_back(beat_out[j]);
   endtask

   task automatic wait_drained();
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      capacity = v;
   endtask

   // Receiver: random pop, plus a long hold when requested.
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_pop <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(0, 99) >= rsp_gap_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         got_res = unesc_result_type'{rsp_out_byte, jsu_pkg::status_type'(rsp_status),
                                      rsp_run_last};
         if (decoded_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: expected no rsp beat, got byte %02h status %0d last %0b", $time,
                     got_res.out_byte, got_res.status, got_res.run_last);
         end else begin
            want_res = decoded_q.pop_front();
            if (got_res !== want_res) begin
               mismatch_count++;
               $display("%0t: expected byte %02h status %0d last %0b, got byte %02h status %0d last %0b",
                        $time, want_res.out_byte, want_res.status, want_res.run_last,
                        got_res.out_byte, got_res.status, got_res.run_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [15:0] caps [6];
      int sent;
      caps = '{16'h0000, 16'd3, 16'hffff, 16'd1, 16'd24, 16'h0000};
      caps[5] = 16'($urandom_range(2, 60));
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_beat(dir_rows[i].b, dir_rows[i].eos, dir_rows[i].typed,
                   unesc_result_type'{dir_rows[i].want_byte, dir_rows[i].want_st, 1'b1});
      req_push <= 1'b0;

      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         write_capacity(caps[ph]);
         req_gap_pct = (ph < 2) ? 12 : (ph < 4) ? 68 : 0;
         rsp_gap_pct = (ph < 2) ? 68 : (ph < 4) ? 12 : 0;
         // receiver holds off while the sender keeps pushing
         if (ph == 4) hold_req <= ~hold_req;
         sent = 0;
         while (sent < PHASE_BEATS) begin
            build_string();
            foreach (str_q[i]) begin
               sent++;
               send_beat(str_q[i], i == str_q.size() - 1, 1'b0, '0);
            end
         end
         req_push <= 1'b0;
      end

      wait_drained();
      if (mismatch_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
`default_nettype wire
